[rtl/fse_pkg.sv]
// Shared types, constants and the sine table generator for the Fourier series evaluator.
// Used by fse_sin_rom, fse_cell and fourier_series_evaluator_core; depends on nothing.
package fse_pkg;

    // Default parameter values.
    localparam int MAX_HARMONICS   = 3;
    localparam int TABLE_ADDR_BITS = 10;

    // Field and datapath widths.
    localparam int PHASE_W = 16;
    localparam int COEF_W  = 16;
    localparam int HARM_W  = 2;
    localparam int OUT_W   = 19;
    localparam int FRAC_SH = 15;
    localparam int ACC_W   = OUT_W + FRAC_SH;
    localparam int SINE_W  = 15;
    localparam int SVAL_W  = SINE_W + 2;
    localparam int PROD_W  = COEF_W + SVAL_W;

    // Configuration port.
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 5;
    localparam int REG_HARM_RESET = 1;

    // Half of pi in Q30, and the rounding constant for Q.23 to Q.8.
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam int ROUND_HALF = 1 << (FRAC_SH - 1);

    // Divisors of the successive Taylor terms of the sine, (n+1)*(n+2) for odd n.
    localparam longint unsigned TAYLOR_D3  = 64'd6;
    localparam longint unsigned TAYLOR_D5  = 64'd20;
    localparam longint unsigned TAYLOR_D7  = 64'd42;
    localparam longint unsigned TAYLOR_D9  = 64'd72;
    localparam longint unsigned TAYLOR_D11 = 64'd110;
    localparam longint unsigned TAYLOR_D13 = 64'd156;
    localparam longint unsigned TAYLOR_D15 = 64'd210;
    localparam longint unsigned TAYLOR_D17 = 64'd272;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_HARM,
        REG_DC,
        REG_COS1,
        REG_SIN1,
        REG_COS2,
        REG_SIN2,
        REG_COS3,
        REG_SIN3
    } t_reg_idx;

    // Data handed from one harmonic cell to the next.
    typedef struct packed {
        logic [PHASE_W-1:0]      phase;
        logic [PHASE_W-1:0]      pk;
        logic signed [ACC_W-1:0] acc;
    } t_tok;

    // Configuration seen by one harmonic cell.
    typedef struct packed {
        logic [HARM_W-1:0]        harm_count;
        logic signed [COEF_W-1:0] cos_coef;
        logic signed [COEF_W-1:0] sin_coef;
    } t_cell_cfg;

    // One quarter-wave sample in unsigned Q0.15, evaluated at elaboration only.
    // The angle is formed in Q30 and the Taylor series is summed up to the x^17 term,
    // each term truncated, with the signs alternating from the x^3 term on.
    function automatic logic [SINE_W-1:0] sin_entry(input int unsigned idx,
                                                    input int unsigned bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned steps;
        longint unsigned r;
        longint          sum;
        steps = 64'd1 << bits;
        x     = (PI_HALF_Q30 * idx + (steps >> 1)) >> bits;
        x2    = (x * x) >> 30;
        term  = x;
        sum   = longint'(x);
        term  = ((term * x2) >> 30) / TAYLOR_D3;
        sum  -= longint'(term);
        term  = ((term * x2) >> 30) / TAYLOR_D5;
        sum  += longint'(term);
        term  = ((term * x2) >> 30) / TAYLOR_D7;
        sum  -= longint'(term);
        term  = ((term * x2) >> 30) / TAYLOR_D9;
        sum  += longint'(term);
        term  = ((term * x2) >> 30) / TAYLOR_D11;
        sum  -= longint'(term);
        term  = ((term * x2) >> 30) / TAYLOR_D13;
        sum  += longint'(term);
        term  = ((term * x2) >> 30) / TAYLOR_D15;
        sum  -= longint'(term);
        term  = ((term * x2) >> 30) / TAYLOR_D17;
        sum  += longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        r = (longint'(sum) + 16384) >> 15;
        if (r > 32767) begin
            r = 32767;
        end
        return r[SINE_W-1:0];
    endfunction

endpackage

[rtl/fourier_series_evaluator_core.sv]
// Top level of the Fourier series evaluator: configuration registers, cell chain, output stage.
// Depends on fse_pkg and fse_cell.

// The block takes one phase transfer per clock while the chain is not stalled and returns one
// series value per phase, in order. Each phase passes through a chain of MAX_HARMONICS
// harmonic cells and a rounding register, 3*MAX_HARMONICS+1 registers in all. Each cell
// registers its sine table read, then the two coefficient multiplies, then the accumulation;
// the sustained rate is one item per cycle while the output accepts. Stalls on the output side
// are absorbed by empty stages first, so input is still taken while a finished result waits,
// as long as an empty stage remains. Registers sit at byte addresses 4*index and must only be
// written while no phase is in flight; a harmonic count of zero returns the constant term
// alone.
module fourier_series_evaluator_core #(
    parameter int MAX_HARMONICS   = fse_pkg::MAX_HARMONICS,
    parameter int TABLE_ADDR_BITS = fse_pkg::TABLE_ADDR_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fse_pkg::APB_AW-1:0]        paddr,
    input  logic [fse_pkg::APB_DW-1:0]        pwdata,
    output logic [fse_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [fse_pkg::PHASE_W-1:0]       i_phase,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [fse_pkg::OUT_W-1:0]  o_series_value
);

    localparam int NumCoef = 7;

    fse_pkg::t_reg_idx                  reg_idx;
    logic                               cfg_wr;
    logic [2:0]                         coef_idx;
    logic [fse_pkg::HARM_W-1:0]         r_harm;
    logic signed [fse_pkg::COEF_W-1:0]  r_coef [NumCoef];

    logic                               c_valid [MAX_HARMONICS+1];
    logic                               c_ready [MAX_HARMONICS+1];
    fse_pkg::t_tok                      c_tok   [MAX_HARMONICS+1];

    logic                               out_en;
    logic signed [fse_pkg::ACC_W-1:0]   rounded;
    logic                               r_out_valid;
    logic signed [fse_pkg::OUT_W-1:0]   r_out_value;

    // Register access decode.
    assign reg_idx  = fse_pkg::t_reg_idx'(paddr[4:2]);
    assign coef_idx = paddr[4:2] - 3'd1;
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_harm <= fse_pkg::HARM_W'(fse_pkg::REG_HARM_RESET);
            for (int i = 0; i < NumCoef; i++) begin
                r_coef[i] <= '0;
            end
        end else if (cfg_wr) begin
            unique case (reg_idx)
                fse_pkg::REG_HARM: r_harm <= pwdata[fse_pkg::HARM_W-1:0];
                default:           r_coef[coef_idx] <= pwdata[fse_pkg::COEF_W-1:0];
            endcase
        end
    end

    // Read back.
    always_comb begin
        unique case (reg_idx)
            fse_pkg::REG_HARM: prdata = fse_pkg::APB_DW'(r_harm);
            default:           prdata = fse_pkg::APB_DW'(unsigned'(r_coef[coef_idx]));
        endcase
    end

    // Head of the chain: the constant term scaled to Q.23, harmonic phase starting at zero.
    assign c_valid[0]     = i_in_valid;
    assign o_in_ready     = c_ready[0];
    assign c_tok[0].phase = i_phase;
    assign c_tok[0].pk    = '0;
    assign c_tok[0].acc   = fse_pkg::ACC_W'(r_coef[0]) <<< fse_pkg::FRAC_SH;

    // One cell per harmonic, each adding its cosine and sine terms.
    for (genvar gk = 1; gk <= MAX_HARMONICS; gk++) begin : g_cell
        fse_pkg::t_cell_cfg cell_cfg;

        assign cell_cfg.harm_count = r_harm;
        assign cell_cfg.cos_coef   = r_coef[2*gk-1];
        assign cell_cfg.sin_coef   = r_coef[2*gk];

        fse_cell #(
            .HARM_IDX       (gk),
            .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cfg  (cell_cfg),
            .i_valid(c_valid[gk-1]),
            .o_ready(c_ready[gk-1]),
            .i_tok  (c_tok[gk-1]),
            .o_valid(c_valid[gk]),
            .i_ready(c_ready[gk]),
            .o_tok  (c_tok[gk])
        );
    end

    // Round half up from Q.23 to Q.8; dropping the low bits floors the biased sum.
    assign out_en                 = !r_out_valid || i_out_ready;
    assign c_ready[MAX_HARMONICS] = out_en;
    assign rounded = c_tok[MAX_HARMONICS].acc + fse_pkg::ACC_W'(fse_pkg::ROUND_HALF);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= c_valid[MAX_HARMONICS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en) begin
            r_out_value <= rounded[fse_pkg::ACC_W-1:fse_pkg::FRAC_SH];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_series_value = r_out_value;

    // With the output register empty the whole chain can move, so input must be taken.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input not ready although the output register is empty");

    // A write to the harmonic count lands in its register.
    a_harm_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && paddr[4:2] == fse_pkg::REG_HARM) |=>
            r_harm == $past(pwdata[fse_pkg::HARM_W-1:0]))
        else $error("harmonic count write lost");

    // A write to the constant term lands in its register.
    a_dc_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && paddr[4:2] == fse_pkg::REG_DC) |=>
            r_coef[0] == $past(pwdata[fse_pkg::COEF_W-1:0]))
        else $error("constant term write lost");

endmodule

[rtl/fse_sin_rom.sv]
// Quarter-wave sine table with two registered read ports.
// Depends on fse_pkg for the table generator.
module fse_sin_rom #(
    parameter int TABLE_ADDR_BITS = fse_pkg::TABLE_ADDR_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [TABLE_ADDR_BITS:0]     i_addr_a,
    input  logic [TABLE_ADDR_BITS:0]     i_addr_b,
    output logic [fse_pkg::SINE_W-1:0]   o_data_a,
    output logic [fse_pkg::SINE_W-1:0]   o_data_b
);

    localparam int NumEntries = (1 << TABLE_ADDR_BITS) + 1;

    logic [fse_pkg::SINE_W-1:0] tab [NumEntries];
    logic [fse_pkg::SINE_W-1:0] r_data_a;
    logic [fse_pkg::SINE_W-1:0] r_data_b;

    // Constant contents, one sample per quarter-wave step.
    for (genvar gi = 0; gi < NumEntries; gi++) begin : g_tab
        assign tab[gi] = fse_pkg::sin_entry(gi, TABLE_ADDR_BITS);
    end

    // Registered read on both ports, held while the stage is stalled.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= tab[i_addr_a];
            r_data_b <= tab[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

[rtl/fse_cell.sv]
// One harmonic cell: harmonic phase, table lookup, two products and accumulation.
// Depends on fse_pkg and fse_sin_rom.
module fse_cell #(
    parameter int HARM_IDX        = 1,
    parameter int TABLE_ADDR_BITS = fse_pkg::TABLE_ADDR_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fse_pkg::t_cell_cfg i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  fse_pkg::t_tok      i_tok,
    output logic               o_valid,
    input  logic               i_ready,
    output fse_pkg::t_tok      o_tok
);

    localparam logic [TABLE_ADDR_BITS:0] TopIdx = {1'b1, {TABLE_ADDR_BITS{1'b0}}};

    logic                              en1;
    logic                              en2;
    logic                              en3;
    logic                              cell_on;
    logic [fse_pkg::PHASE_W-1:0]       pk;
    logic [1:0]                        cos_quad;
    logic [TABLE_ADDR_BITS:0]          frac_idx;
    logic [TABLE_ADDR_BITS:0]          sin_idx;
    logic [TABLE_ADDR_BITS:0]          cos_idx;
    logic [fse_pkg::SINE_W-1:0]        rom_sin;
    logic [fse_pkg::SINE_W-1:0]        rom_cos;
    logic signed [fse_pkg::SVAL_W-1:0] sin_val;
    logic signed [fse_pkg::SVAL_W-1:0] cos_val;
    logic signed [fse_pkg::PROD_W-1:0] n_prod_c;
    logic signed [fse_pkg::PROD_W-1:0] n_prod_s;
    logic signed [fse_pkg::ACC_W-1:0]  n_acc;

    logic                              r_v1;
    logic                              r_v2;
    logic                              r_v3;
    logic                              r_sneg1;
    logic                              r_cneg1;
    fse_pkg::t_tok                     r_tok1;
    fse_pkg::t_tok                     r_tok2;
    fse_pkg::t_tok                     r_tok3;
    logic signed [fse_pkg::PROD_W-1:0] r_prod_c;
    logic signed [fse_pkg::PROD_W-1:0] r_prod_s;

    // A stage moves on when it is empty or the stage after it moves on.
    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign cell_on = int'(i_cfg.harm_count) >= HARM_IDX;

    // Harmonic phase is the previous one plus the base phase, wrapping each period.
    assign pk       = i_tok.pk + i_tok.phase;
    assign frac_idx = {1'b0, pk[13 -: TABLE_ADDR_BITS]};
    assign sin_idx  = pk[14] ? (TopIdx - frac_idx) : frac_idx;
    assign cos_quad = pk[15:14] + 2'd1;
    assign cos_idx  = cos_quad[0] ? (TopIdx - frac_idx) : frac_idx;

    fse_sin_rom #(
        .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
    ) u_rom (
        .i_clk   (i_clk),
        .i_en    (en1),
        .i_addr_a(sin_idx),
        .i_addr_b(cos_idx),
        .o_data_a(rom_sin),
        .o_data_b(rom_cos)
    );

    // Quadrant sign and the two coefficient products.
    assign sin_val  = r_sneg1 ? -$signed({2'b00, rom_sin}) : $signed({2'b00, rom_sin});
    assign cos_val  = r_cneg1 ? -$signed({2'b00, rom_cos}) : $signed({2'b00, rom_cos});
    assign n_prod_c = fse_pkg::PROD_W'(i_cfg.cos_coef) * fse_pkg::PROD_W'(cos_val);
    assign n_prod_s = fse_pkg::PROD_W'(i_cfg.sin_coef) * fse_pkg::PROD_W'(sin_val);

    // Accumulate only when this harmonic lies within the configured order.
    assign n_acc = cell_on
        ? r_tok2.acc + fse_pkg::ACC_W'(r_prod_c) + fse_pkg::ACC_W'(r_prod_s)
        : r_tok2.acc;

    // Valid flags of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Payload of the three stages.
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_tok1.phase <= i_tok.phase;
            r_tok1.pk    <= pk;
            r_tok1.acc   <= i_tok.acc;
            r_sneg1      <= pk[15];
            r_cneg1      <= cos_quad[1];
        end
        if (en2) begin
            r_tok2   <= r_tok1;
            r_prod_c <= n_prod_c;
            r_prod_s <= n_prod_s;
        end
        if (en3) begin
            r_tok3.phase <= r_tok2.phase;
            r_tok3.pk    <= r_tok2.pk;
            r_tok3.acc   <= n_acc;
        end
    end

    assign o_valid = r_v3;
    assign o_tok   = r_tok3;

endmodule
